// ===== hw/rtl/plcd_pkg.sv =====
package plcd_pkg;

	// Default number of pieces and the packed register layout
	localparam int MAX_PIECES_DEF = 4;
	localparam int FIELD_W        = 16;
	localparam int FIELD_N        = 4;

	// Field widths of the channels
	localparam int VEH_W   = 10;
	localparam int CAP_W   = 16;
	localparam int TT_W    = 24;
	localparam int DELAY_W = 32;

	// Signed accumulator width for heights and piece delays
	localparam int ACC_W = 52;

	// Configuration port
	localparam int ADDR_W = 5;
	localparam int DATA_W = 64;
	localparam logic [1:0] REG_PIECE_COUNT  = 2'd0;
	localparam logic [1:0] REG_PIECE_THRESH = 2'd1;
	localparam logic [1:0] REG_PIECE_SLOPE  = 2'd2;

	// Per-cell configuration view
	typedef struct packed {
		logic [FIELD_W-1:0] thr_cur;
		logic [FIELD_W-1:0] thr_nxt;
		logic [FIELD_W-1:0] slope;
		logic               active;
		logic               chain_on;
	} piece_cfg_t;

	// Transaction moving along the piece cells (height and best are signed)
	typedef struct packed {
		logic [VEH_W-1:0] veh;
		logic [CAP_W-1:0] cap;
		logic [TT_W-1:0]  tt;
		logic             dummy;
		logic [ACC_W-1:0] height;
		logic [ACC_W-1:0] best;
	} piece_item_t;

	// Transaction moving along the divider cells
	typedef struct packed {
		logic [CAP_W-1:0]   rem;
		logic [DELAY_W-1:0] quo;
		logic [CAP_W-1:0]   cap;
		logic               clr;
		logic               ovf;
		logic               sat;
	} div_item_t;

endpackage

// ===== hw/rtl/plcd_in_if.sv =====
interface plcd_in_if;
	logic                           valid;
	logic                           ready;
	logic [plcd_pkg::VEH_W-1:0]     vehicle_count;
	logic [plcd_pkg::CAP_W-1:0]     arc_capacity;
	logic [plcd_pkg::TT_W-1:0]      arc_travel_time;
	logic                           arc_is_dummy;

	modport source (output valid, output vehicle_count, output arc_capacity,
		output arc_travel_time, output arc_is_dummy, input ready);
	modport sink (input valid, input vehicle_count, input arc_capacity,
		input arc_travel_time, input arc_is_dummy, output ready);
endinterface

// ===== hw/rtl/plcd_out_if.sv =====
interface plcd_out_if;
	logic                         valid;
	logic                         ready;
	logic [plcd_pkg::DELAY_W-1:0] delay;
	logic                         saturated;

	modport source (output valid, output delay, output saturated, input ready);
	modport sink (input valid, input delay, input saturated, output ready);
endinterface

// ===== hw/rtl/plcd_piece_cell.sv =====
module plcd_piece_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  plcd_pkg::piece_cfg_t  cfg,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  plcd_pkg::piece_item_t in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output plcd_pkg::piece_item_t out_item
);

	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	plcd_pkg::piece_item_t item_s1, item_s2, item_s3;
	logic [31:0]           start_s1, next_s1;
	logic signed [48:0]    dx_s2, rise_s2;
	logic                  hit_s2;

	logic [27:0]                       x;
	logic signed [32:0]                diff, dn;
	logic signed [16:0]                slope_sx;
	logic signed [plcd_pkg::ACC_W-1:0] d, h_next;
	plcd_pkg::piece_item_t             item_nxt;

	// Stage handshake: a stage takes a new transaction when empty or draining
	assign rdy_s3    = !v_s3 || out_ready;
	assign rdy_s2    = !v_s2 || rdy_s3;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign in_ready  = rdy_s1;
	assign out_valid = v_s3;
	assign out_item  = item_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	// Count scaled by 2^18, offsets from this piece's start and to the next start
	always_comb begin
		x        = {item_s1.veh, 18'd0};
		slope_sx = $signed({1'b0, cfg.slope});
		diff     = $signed({5'd0, x}) - $signed({1'b0, start_s1});
		dn       = $signed({1'b0, next_s1}) - $signed({1'b0, start_s1});
	end

	// Piece delay candidate and height carried to the next piece
	always_comb begin
		d      = $signed(item_s2.height) + plcd_pkg::ACC_W'(dx_s2);
		h_next = $signed(item_s2.height) + plcd_pkg::ACC_W'(rise_s2);
	end

	// Transaction leaving this cell: best delay so far and accumulated height
	always_comb begin
		item_nxt = item_s2;
		if (cfg.active && hit_s2 && (d > $signed(item_s2.best))) begin
			item_nxt.best = d;
		end
		if (cfg.chain_on) begin
			item_nxt.height = h_next;
		end
	end

	always_ff @(posedge clk) begin
		// s1: piece start and next start in count units
		if (in_valid && rdy_s1) begin
			item_s1  <= in_item;
			start_s1 <= 32'(cfg.thr_cur) * 32'(in_item.cap);
			next_s1  <= 32'(cfg.thr_nxt) * 32'(in_item.cap);
		end
		// s2: slope products
		if (v_s1 && rdy_s2) begin
			item_s2 <= item_s1;
			dx_s2   <= 49'(slope_sx) * 49'(diff);
			rise_s2 <= 49'(slope_sx) * 49'(dn);
			hit_s2  <= !diff[32] && (diff != 33'sd0);
		end
		// s3: keep the best delay, accumulate height
		if (v_s2 && rdy_s3) begin
			item_s3 <= item_nxt;
		end
	end

endmodule

// ===== hw/rtl/plcd_scale.sv =====
module plcd_scale (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  plcd_pkg::piece_item_t in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output plcd_pkg::div_item_t   out_item
);

	logic v_s1, v_s2;
	logic rdy_s1, rdy_s2;

	logic [50:0]                 phi_s1;
	logic [47:0]                 plo_s1;
	logic [plcd_pkg::CAP_W-1:0]  cap_s1;
	logic                        dummy_s1, pos_s1;
	plcd_pkg::div_item_t         item_s2;

	logic [51:0] scaled;
	logic        big, cap0, clr;

	assign rdy_s2    = !v_s2 || out_ready;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign in_ready  = rdy_s1;
	assign out_valid = v_s2;
	assign out_item  = item_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	// Travel time times the numerator, split at bit 24
	always_comb begin
		scaled = 52'(phi_s1) + 52'(plo_s1[47:24]);
		cap0   = (cap_s1 == '0);
		clr    = dummy_s1 || cap0 || !pos_s1;
		big    = scaled[51:32] >= 20'(cap_s1);
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			phi_s1   <= 51'(in_item.tt) * 51'(in_item.best[50:24]);
			plo_s1   <= 48'(in_item.tt) * 48'(in_item.best[23:0]);
			cap_s1   <= in_item.cap;
			dummy_s1 <= in_item.dummy;
			pos_s1   <= ($signed(in_item.best) > $signed(plcd_pkg::ACC_W'(0)));
		end
		// Quotient above 32 bits exactly when the top word reaches the divisor
		if (v_s1 && rdy_s2) begin
			item_s2.rem <= scaled[47:32];
			item_s2.quo <= scaled[31:0];
			item_s2.cap <= cap_s1;
			item_s2.clr <= clr;
			item_s2.ovf <= !clr && big;
			item_s2.sat <= (!dummy_s1 && cap0) || (!clr && big);
		end
	end

endmodule

// ===== hw/rtl/plcd_div_cell.sv =====
module plcd_div_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  plcd_pkg::div_item_t in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output plcd_pkg::div_item_t out_item
);

	logic                v_s1;
	plcd_pkg::div_item_t item_s1;

	logic [plcd_pkg::CAP_W:0] r2, r2_sub;
	logic                     ge;
	plcd_pkg::div_item_t      item_nxt;

	assign in_ready  = !v_s1 || out_ready;
	assign out_valid = v_s1;
	assign out_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	// One restoring step: bring down the next dividend bit, subtract if it fits
	always_comb begin
		r2       = {in_item.rem, in_item.quo[plcd_pkg::DELAY_W-1]};
		ge       = r2 >= {1'b0, in_item.cap};
		r2_sub   = r2 - {1'b0, in_item.cap};
		item_nxt = in_item;
		item_nxt.rem = ge ? r2_sub[plcd_pkg::CAP_W-1:0] : r2[plcd_pkg::CAP_W-1:0];
		item_nxt.quo = {in_item.quo[plcd_pkg::DELAY_W-2:0], ge};
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_nxt;
		end
	end

endmodule

// ===== hw/rtl/piecewise_linear_congestion_delay_top.sv =====
// Channel  Dir  Handshake      Payload
// in_ch    in   valid/ready    vehicle_count, arc_capacity, arc_travel_time, arc_is_dummy
// out_ch   out  valid/ready    delay, saturated
// apb      in   psel/penable   paddr, pwdata, prdata (64-bit registers at 8*index)
//
// One transaction per cycle while the output channel is ready; three stages per
// piece cell, two scaling stages and one quotient bit per divider cell.
// Reset clears the stage valid bits, the threshold and slope registers, and sets the piece count to one.
// Each stage holds its transaction while the next one is full; empty stages keep
// filling, so input is taken while a finished result waits at the output.
module piecewise_linear_congestion_delay_top #(
	parameter int MAX_PIECES = plcd_pkg::MAX_PIECES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	plcd_in_if.sink                      in_ch,
	plcd_out_if.source                   out_ch,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [plcd_pkg::ADDR_W-1:0]  paddr,
	input  logic [plcd_pkg::DATA_W-1:0]  pwdata,
	output logic [plcd_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);

	localparam int DIV_N = plcd_pkg::DELAY_W;

	logic [2:0]                  piece_count_q;
	logic [plcd_pkg::DATA_W-1:0] piece_thr_q, piece_slope_q;
	logic                        wr_en;
	logic [2:0]                  n_eff;

	logic                  pc_v   [MAX_PIECES+1];
	logic                  pc_r   [MAX_PIECES+1];
	plcd_pkg::piece_item_t pc_item[MAX_PIECES+1];

	logic                dv_v   [DIV_N+1];
	logic                dv_r   [DIV_N+1];
	plcd_pkg::div_item_t dv_item[DIV_N+1];

	// Configuration registers
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			piece_count_q <= 3'd1;
			piece_thr_q   <= '0;
			piece_slope_q <= '0;
		end else if (wr_en) begin
			unique case (paddr[4:3])
				plcd_pkg::REG_PIECE_COUNT:  piece_count_q <= pwdata[2:0];
				plcd_pkg::REG_PIECE_THRESH: piece_thr_q   <= pwdata;
				plcd_pkg::REG_PIECE_SLOPE:  piece_slope_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:3])
			plcd_pkg::REG_PIECE_COUNT:  prdata = {61'd0, piece_count_q};
			plcd_pkg::REG_PIECE_THRESH: prdata = piece_thr_q;
			plcd_pkg::REG_PIECE_SLOPE:  prdata = piece_slope_q;
			default:                    prdata = '0;
		endcase
	end

	// Pieces in use, clamped to the number of cells
	assign n_eff = (piece_count_q > 3'(MAX_PIECES)) ? 3'(MAX_PIECES) : piece_count_q;

	// Head of the piece chain
	assign pc_v[0]           = in_ch.valid;
	assign in_ch.ready       = pc_r[0];
	assign pc_item[0].veh    = in_ch.vehicle_count;
	assign pc_item[0].cap    = in_ch.arc_capacity;
	assign pc_item[0].tt     = in_ch.arc_travel_time;
	assign pc_item[0].dummy  = in_ch.arc_is_dummy;
	assign pc_item[0].height = '0;
	assign pc_item[0].best   = '0;

	// One cell per piece
	for (genvar gi = 0; gi < MAX_PIECES; gi++) begin : g_piece
		plcd_pkg::piece_cfg_t cfg;

		assign cfg.thr_cur  = piece_thr_q[plcd_pkg::FIELD_W*gi +: plcd_pkg::FIELD_W];
		assign cfg.thr_nxt  = piece_thr_q[plcd_pkg::FIELD_W*((gi+1) % plcd_pkg::FIELD_N)
			+: plcd_pkg::FIELD_W];
		assign cfg.slope    = piece_slope_q[plcd_pkg::FIELD_W*gi +: plcd_pkg::FIELD_W];
		assign cfg.active   = 3'(gi) < n_eff;
		assign cfg.chain_on = 3'(gi + 1) < n_eff;

		plcd_piece_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cfg       (cfg),
			.in_valid  (pc_v[gi]),
			.in_ready  (pc_r[gi]),
			.in_item   (pc_item[gi]),
			.out_valid (pc_v[gi+1]),
			.out_ready (pc_r[gi+1]),
			.out_item  (pc_item[gi+1])
		);
	end

	// Scale by travel time and set up the division
	plcd_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pc_v[MAX_PIECES]),
		.in_ready  (pc_r[MAX_PIECES]),
		.in_item   (pc_item[MAX_PIECES]),
		.out_valid (dv_v[0]),
		.out_ready (dv_r[0]),
		.out_item  (dv_item[0])
	);

	// One quotient bit per cell
	for (genvar gk = 0; gk < DIV_N; gk++) begin : g_div
		plcd_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (dv_v[gk]),
			.in_ready  (dv_r[gk]),
			.in_item   (dv_item[gk]),
			.out_valid (dv_v[gk+1]),
			.out_ready (dv_r[gk+1]),
			.out_item  (dv_item[gk+1])
		);
	end

	// Result selection
	assign out_ch.valid     = dv_v[DIV_N];
	assign dv_r[DIV_N]      = out_ch.ready;
	assign out_ch.delay     = dv_item[DIV_N].ovf ? '1 :
		(dv_item[DIV_N].clr ? '0 : dv_item[DIV_N].quo);
	assign out_ch.saturated = dv_item[DIV_N].sat;

endmodule

// ===== dv/plcd_delay_check.sv =====
`timescale 1ns / 100ps

// Watches the arc and delay channels plus the register port, keeps its own copy of the
// piece configuration and compares every delay result against the predicted one.
module plcd_delay_check
	import plcd_pkg::*;
#(
	parameter int MAX_PIECES = MAX_PIECES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	plcd_in_if                in_ch,
	plcd_out_if               out_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output int                mismatch_count,
	output int                results_owed
);

	typedef struct packed {
		logic [DELAY_W-1:0] delay;
		logic               saturated;
	} delay_result_t;

	// Shadow of the piece configuration
	logic [2:0]  piece_total;
	logic [63:0] thresh_word;
	logic [63:0] slope_word;

	// Delays predicted for accepted arcs, oldest first
	delay_result_t owed_delays[$];

	// Congestion delay of one arc under the current piece configuration.
	// Counts are scaled by 2^18, so a piece start is threshold * capacity exactly.
	function automatic delay_result_t congestion_delay(
		input logic [VEH_W-1:0] veh,
		input logic [CAP_W-1:0] cap,
		input logic [TT_W-1:0]  tt,
		input logic             dummy
	);
		delay_result_t res;
		longint x, start, next_start, slope, height, best, piece_delay;
		longint unsigned num, scaled, quo;
		int n, i;

		res = '0;
		if (dummy)
			return res;
		if (cap == '0) begin
			res.saturated = 1'b1;
			return res;
		end
		n = (int'(piece_total) > MAX_PIECES) ? MAX_PIECES : int'(piece_total);
		x = longint'(veh) <<< 18;
		height = 0;
		best = 0;
		for (i = 0; i < n; i++) begin
			start = longint'(thresh_word[16*i +: 16]) * longint'(cap);
			slope = longint'(slope_word[16*i +: 16]);
			// a piece counts only strictly above its start
			if (x > start) begin
				piece_delay = height + slope * (x - start);
				if (piece_delay > best)
					best = piece_delay;
			end
			// rise up to the next start; negative when thresholds descend
			if (i + 1 < n) begin
				next_start = longint'(thresh_word[16*(i+1) +: 16]) * longint'(cap);
				height += slope * (next_start - start);
			end
		end
		if (best > 0) begin
			num = best;
			scaled = 64'(tt) * (num >> 24) + ((64'(tt) * (num & 64'hFF_FFFF)) >> 24);
			quo = scaled / 64'(cap);
			if (quo > 64'hFFFF_FFFF) begin
				res.delay = '1;
				res.saturated = 1'b1;
			end else begin
				res.delay = quo[DELAY_W-1:0];
			end
		end
		return res;
	endfunction

	// Register writes, prediction on input, comparison on output
	always @(posedge clk or negedge arst_n) begin : watch
		delay_result_t got, want;
		int new_errs;

		if (!arst_n) begin
			piece_total <= 3'd1;
			thresh_word <= '0;
			slope_word <= '0;
			owed_delays.delete();
			mismatch_count <= 0;
			results_owed <= 0;
		end else begin
			new_errs = 0;
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:3])
					REG_PIECE_COUNT:  piece_total <= pwdata[2:0];
					REG_PIECE_THRESH: thresh_word <= pwdata;
					REG_PIECE_SLOPE:  slope_word <= pwdata;
					default: ;
				endcase
			end

			if (in_ch.valid && in_ch.ready)
				owed_delays.insert(owed_delays.size(), congestion_delay(in_ch.vehicle_count,
					in_ch.arc_capacity, in_ch.arc_travel_time, in_ch.arc_is_dummy));

			if (out_ch.valid && out_ch.ready) begin
				got.delay = out_ch.delay;
				got.saturated = out_ch.saturated;
				if (owed_delays.size() == 0) begin
					$error("unexpected transaction: delay %08h saturated %0b",
						got.delay, got.saturated);
					new_errs++;
				end else begin
					want = owed_delays.pop_front();
					if (got.delay !== want.delay) begin
						$error("delay: expected %08h, got %08h", want.delay, got.delay);
						new_errs++;
					end
					if (got.saturated !== want.saturated) begin
						$error("saturated: expected %0b, got %0b",
							want.saturated, got.saturated);
						new_errs++;
					end
				end
			end

			mismatch_count <= mismatch_count + new_errs;
			results_owed <= owed_delays.size();
		end
	end

endmodule

// ===== dv/piecewise_linear_congestion_delay_top_test.sv =====
`timescale 1ns / 100ps

module piecewise_linear_congestion_delay_top_test;
	import plcd_pkg::*;

	// Register slot past the end of the map; writes there must be ignored
	localparam logic [1:0] REG_UNMAPPED = 2'd3;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int DRAIN_CYCLES  = 60;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_ITEMS   = 140;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	int          mismatch_count;
	int          results_owed;
	int          cycle_count = 0;
	int          burst_left = 0;
	logic [63:0] thresh_shadow = '0;

	plcd_in_if  in_ch();
	plcd_out_if out_ch();

	piecewise_linear_congestion_delay_top #(
		.MAX_PIECES(MAX_PIECES_DEF)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	plcd_delay_check #(
		.MAX_PIECES(MAX_PIECES_DEF)
	) delay_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_ch          (in_ch),
		.out_ch         (out_ch),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.mismatch_count (mismatch_count),
		.results_owed   (results_owed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Delay channel back-pressure, with the pattern picked at random from four modes
	initial begin : out_stall
		stall_mode_t stall_mode;
		int tick;

		stall_mode = STALL_NONE;
		tick = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			tick++;
			if (tick % 200 == 0)
				stall_mode = stall_mode_t'($urandom_range(0, 3));
			case (stall_mode)
				STALL_NONE:  out_ch.ready <= 1'b1;
				STALL_LIGHT: out_ch.ready <= ($urandom_range(0, 3) != 0);
				STALL_HEAVY: out_ch.ready <= ($urandom_range(0, 3) == 0);
				default:     out_ch.ready <= ((tick % 8) < 3);
			endcase
		end
	end

	// Register write: setup phase, then access phase until pready
	task automatic reg_write(input logic [1:0] idx, input logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_PIECE_THRESH)
			thresh_shadow = value;
	endtask

	// One arc transaction; bursts of random length separated by random gaps
	task automatic send_arc(
		input logic [VEH_W-1:0] veh,
		input logic [CAP_W-1:0] cap,
		input logic [TT_W-1:0]  tt,
		input logic             dummy
	);
		int gap;

		in_ch.vehicle_count <= veh;
		in_ch.arc_capacity <= cap;
		in_ch.arc_travel_time <= tt;
		in_ch.arc_is_dummy <= dummy;
		in_ch.valid <= 1'b1;
		do @(posedge clk); while (!in_ch.ready);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
				: $urandom_range(0, 12);
		end
	endtask

	// Stop sending and wait until every predicted delay has come out
	task automatic settle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0) @(posedge clk);
	endtask

	// Random piece setup: mostly ascending thresholds, sometimes anything
	task automatic random_config();
		logic [63:0] thr, slp;
		logic [2:0] count;
		int acc, i, pick;

		pick = $urandom_range(0, 9);
		if (pick == 0)
			count = 3'd0;
		else if (pick == 1)
			count = 3'($urandom_range(5, 7));
		else
			count = 3'($urandom_range(1, 4));

		if ($urandom_range(0, 4) == 0) begin
			thr = {$urandom, $urandom};
		end else begin
			acc = $urandom_range(0, 16'h0800);
			for (i = 0; i < 4; i++) begin
				thr[16*i +: 16] = 16'(acc);
				acc += $urandom_range(0, 16'h1000);
				if (acc > 16'hFFFF)
					acc = 16'hFFFF;
			end
		end

		for (i = 0; i < 4; i++) begin
			case ($urandom_range(0, 3))
				0: slp[16*i +: 16] = 16'($urandom_range(0, 255));
				1: slp[16*i +: 16] = 16'($urandom_range(0, 4095));
				2: slp[16*i +: 16] = 16'($urandom_range(0, 65535));
				default: slp[16*i +: 16] = '0;
			endcase
		end

		reg_write(REG_PIECE_COUNT, 64'(count));
		reg_write(REG_PIECE_THRESH, thr);
		reg_write(REG_PIECE_SLOPE, slp);
		if ($urandom_range(0, 3) == 0)
			reg_write(REG_UNMAPPED, {$urandom, $urandom});
	endtask

	// Random arc, often placed at or beside a piece start
	task automatic random_arc();
		logic [CAP_W-1:0] cap;
		logic [TT_W-1:0]  tt;
		logic [VEH_W-1:0] veh;
		int pick, piece, nearby;

		pick = $urandom_range(0, 15);
		if (pick == 0)
			cap = '0;
		else if (pick <= 5)
			cap = CAP_W'($urandom_range(1, 255));
		else if (pick <= 10)
			cap = CAP_W'($urandom_range(256, 8191));
		else
			cap = CAP_W'($urandom);

		if ($urandom_range(0, 2) == 0) begin
			piece = $urandom_range(0, 3);
			nearby = int'((64'(thresh_shadow[16*piece +: 16]) * 64'(cap)) >> 18)
				+ int'($urandom_range(0, 2)) - 1;
			if (nearby < 0)
				nearby = 0;
			else if (nearby > 1023)
				nearby = 1023;
			veh = VEH_W'(nearby);
		end else begin
			veh = VEH_W'($urandom_range(0, 1023));
		end

		case ($urandom_range(0, 3))
			0:       tt = TT_W'($urandom_range(0, 4095));
			1:       tt = '1;
			default: tt = TT_W'($urandom);
		endcase

		send_arc(veh, cap, tt, $urandom_range(0, 19) == 0);
	endtask

	initial begin
		int phase, n;

		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_ch.valid <= 1'b0;
		in_ch.vehicle_count <= '0;
		in_ch.arc_capacity <= '0;
		in_ch.arc_travel_time <= '0;
		in_ch.arc_is_dummy <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset configuration: one flat piece
		send_arc(10'd10, 16'h0040, 24'h000100, 1'b0);
		send_arc(10'd5, 16'h0000, 24'h000100, 1'b0);
		send_arc(10'd5, 16'h0000, 24'h000100, 1'b1);
		settle();

		// four ascending pieces; count 1 at capacity 1.0 sits on the third start
		reg_write(REG_PIECE_COUNT, 64'd4);
		reg_write(REG_PIECE_THRESH, 64'h1800_1000_0800_0000);
		reg_write(REG_PIECE_SLOPE, 64'hFFFF_4000_1000_0400);
		send_arc(10'd0, 16'h0040, 24'h000100, 1'b0);
		send_arc(10'd1, 16'h0040, 24'h000100, 1'b0);
		send_arc(10'd2, 16'h0040, 24'h000100, 1'b0);
		send_arc(10'd1023, 16'hFFFF, 24'hFFFFFF, 1'b0);
		send_arc(10'd1023, 16'h0001, 24'hFFFFFF, 1'b0);
		send_arc(10'd1023, 16'hFFFF, 24'h000000, 1'b0);
		send_arc(10'd0, 16'h0000, 24'hFFFFFF, 1'b0);
		send_arc(10'd1023, 16'h0000, 24'hFFFFFF, 1'b1);
		send_arc(10'd1023, 16'h0001, 24'hFFFFFF, 1'b1);
		send_arc(10'd512, 16'h8000, 24'h123456, 1'b0);
		send_arc(10'd767, 16'hFFFF, 24'h800000, 1'b0);
		settle();

		// all-ones thresholds and slopes
		reg_write(REG_PIECE_THRESH, '1);
		reg_write(REG_PIECE_SLOPE, '1);
		send_arc(10'd1023, 16'h0001, 24'hFFFFFF, 1'b0);
		send_arc(10'd0, 16'h0001, 24'hFFFFFF, 1'b0);
		send_arc(10'd1023, 16'hFFFF, 24'hFFFFFF, 1'b0);
		settle();

		// descending thresholds give negative rises
		reg_write(REG_PIECE_COUNT, 64'd3);
		reg_write(REG_PIECE_THRESH, 64'h0000_0400_1000_2000);
		reg_write(REG_PIECE_SLOPE, 64'h0000_0010_2000_0800);
		send_arc(10'd1, 16'h0040, 24'h010000, 1'b0);
		send_arc(10'd4, 16'h0040, 24'h010000, 1'b0);
		send_arc(10'd900, 16'h1000, 24'h0F0000, 1'b0);
		settle();

		// zero pieces, plus a write past the register map
		reg_write(REG_PIECE_COUNT, 64'd0);
		reg_write(REG_UNMAPPED, '1);
		send_arc(10'd1023, 16'h0001, 24'hFFFFFF, 1'b0);
		send_arc(10'd100, 16'h0040, 24'h000100, 1'b0);
		settle();

		// piece count above the maximum is clamped
		reg_write(REG_PIECE_COUNT, 64'd7);
		send_arc(10'd1023, 16'h0001, 24'hFFFFFF, 1'b0);
		send_arc(10'd100, 16'h0040, 24'h000100, 1'b0);
		settle();

		// random configurations, each followed by random arcs
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			random_config();
			for (n = 0; n < PHASE_ITEMS; n++)
				random_arc();
			settle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && results_owed == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
